// ===== design/svenc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// svenc_pkg
// Shared types and constants of the signed varint encoder.
// ---------------------------------------------------------------------------
package svenc_pkg;

    // action codes
    localparam logic [1:0] ACT_PLAIN = 2'd0;
    localparam logic [1:0] ACT_OPT   = 2'd1;
    localparam logic [1:0] ACT_EMPTY = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [7:0] CONT_BIT   = 8'h80;
    localparam logic [7:0] LAST_MASK  = 8'h7F;
    localparam logic [7:0] OPT_MASK   = 8'hBF;
    localparam logic [7:0] EMPTY_BYTE = 8'h40;

    localparam int MAX_BYTES     = 5;
    localparam int QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] value;
        logic [2:0]  nbytes;
    } t_job;

endpackage
`default_nettype wire

// ===== design/svenc_intf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// svenc interfaces
// Valid/ready channels for input items and encoded bytes.
// ---------------------------------------------------------------------------
interface svenc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface svenc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] byte_index;
    logic       last;

    modport source (output valid, output out_byte, output byte_index, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_index, input last,
                    output ready);
endinterface
`default_nettype wire

// ===== design/signed_varint_encoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// signed_varint_encoder_top
// Signed varint encoder: sizing front, job queue, byte serializer.
// ---------------------------------------------------------------------------
// registers in the path: front input, queue, serializer job, output byte
// throughput: one byte per cycle while o_out.ready holds; an item is 1 to 5
//   bytes (its byte count); the serializer has a single output byte register
// items with the unused action code are dropped at the front, no output
// reset: synchronous active low, empties the input stage, queue and output
// ---------------------------------------------------------------------------
module signed_varint_encoder_top #(
    parameter int QUEUE_DEPTH = svenc_pkg::QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    svenc_in_if.sink    i_in,
    svenc_out_if.source o_out
);
    import svenc_pkg::*;

    t_job w_front_job;
    logic w_front_valid;
    logic w_front_ready;
    t_job w_back_job;
    logic w_back_valid;
    logic w_back_ready;

    svenc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_job       (w_front_job),
        .o_job_valid (w_front_valid),
        .i_job_ready (w_front_ready)
    );

    svenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_data  (w_front_job),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .o_pop_data   (w_back_job),
        .o_pop_valid  (w_back_valid),
        .i_pop_ready  (w_back_ready)
    );

    svenc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_back_job),
        .i_job_valid (w_back_valid),
        .o_job_ready (w_back_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire

// ===== design/svenc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// svenc_front
// Registers and sizes an item, pushes it as a job or drops it on ACT_NONE.
// ---------------------------------------------------------------------------
module svenc_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    svenc_in_if.sink              i_in,
    output svenc_pkg::t_job       o_job,
    output logic                  o_job_valid,
    input  wire logic             i_job_ready
);
    import svenc_pkg::*;

    logic        r_valid;
    logic [1:0]  r_action;
    logic [31:0] r_value;

    logic [31:0] w_mag;
    logic [4:0]  w_k1;
    logic [2:0]  w_nbytes;
    logic        w_drop;
    logic        w_done;

    // true when the magnitude is below 2^k
    function automatic logic fits(input logic [31:0] mag, input logic [4:0] k);
        return (mag >> k) == 32'd0;
    endfunction

    // unsigned magnitude, the most negative value reads as 2^31
    assign w_mag = r_value[31] ? (32'd0 - r_value) : r_value;
    assign w_k1  = (r_action == ACT_OPT) ? 5'd5 : 5'd6;

    always_comb begin
        priority if (r_action == ACT_EMPTY) begin
            w_nbytes = 3'd1;
        end else if (fits(w_mag, w_k1)) begin
            w_nbytes = 3'd1;
        end else if (fits(w_mag, w_k1 + 5'd7)) begin
            w_nbytes = 3'd2;
        end else if (fits(w_mag, w_k1 + 5'd14)) begin
            w_nbytes = 3'd3;
        end else if (fits(w_mag, w_k1 + 5'd21)) begin
            w_nbytes = 3'd4;
        end else begin
            w_nbytes = 3'(MAX_BYTES);
        end
    end

    assign w_drop      = r_valid && (r_action == ACT_NONE);
    assign o_job_valid = r_valid && !w_drop;
    assign w_done      = w_drop || (o_job_valid && i_job_ready);
    assign i_in.ready  = !r_valid || w_done;

    assign o_job.action = r_action;
    assign o_job.value  = r_value;
    assign o_job.nbytes = w_nbytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_action <= i_in.action;
            r_value  <= i_in.value;
        end
    end

endmodule
`default_nettype wire

// ===== design/svenc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// svenc_queue
// Small job queue between the sizing front and the byte serializer.
// ---------------------------------------------------------------------------
module svenc_queue #(
    parameter int DEPTH = svenc_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire svenc_pkg::t_job  i_push_data,
    input  wire logic             i_push_valid,
    output logic                  o_push_ready,
    output svenc_pkg::t_job       o_pop_data,
    output logic                  o_pop_valid,
    input  wire logic             i_pop_ready
);
    import svenc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          w_push;
    logic          w_pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        unique case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with unequal pointers");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a push");

endmodule
`default_nettype wire

// ===== design/svenc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// svenc_back
// Serializes one job into varint bytes through an output register.
// ---------------------------------------------------------------------------
module svenc_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire svenc_pkg::t_job  i_job,
    input  wire logic             i_job_valid,
    output logic                  o_job_ready,
    svenc_out_if.source           o_out
);
    import svenc_pkg::*;

    t_job        r_job;
    logic        r_busy;
    logic [2:0]  r_idx;
    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic [2:0]  r_oidx;
    logic        r_olast;

    logic [35:0] w_ext;
    logic [7:0]  w_group;
    logic [7:0]  w_byte;
    logic        w_last;
    logic        w_out_free;
    logic        w_pop;

    assign w_ext = {{4{r_job.value[31]}}, r_job.value};

    always_comb begin
        unique case (r_idx)
            3'd0:    w_group = w_ext[7:0];
            3'd1:    w_group = w_ext[14:7];
            3'd2:    w_group = w_ext[21:14];
            3'd3:    w_group = w_ext[28:21];
            3'd4:    w_group = w_ext[35:28];
            default: w_group = w_ext[7:0];
        endcase
    end

    assign w_last = (r_idx == r_job.nbytes - 3'd1);

    always_comb begin
        priority if (r_job.action == ACT_EMPTY) begin
            w_byte = EMPTY_BYTE;
        end else if (!w_last) begin
            w_byte = w_group | CONT_BIT;
        end else if (r_job.action == ACT_OPT) begin
            w_byte = w_group & LAST_MASK & OPT_MASK;
        end else begin
            w_byte = w_group & LAST_MASK;
        end
    end

    assign w_out_free  = !r_ovalid || o_out.ready;
    // take the next job when idle or as the current one hands over its last byte
    assign w_pop       = i_job_valid && (!r_busy || (w_out_free && w_last));
    assign o_job_ready = !r_busy || (w_out_free && w_last);

    assign o_out.valid      = r_ovalid;
    assign o_out.out_byte   = r_obyte;
    assign o_out.byte_index = r_oidx;
    assign o_out.last       = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_ovalid <= r_busy;
            end
            if (w_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy && w_out_free) begin
                if (w_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_job <= i_job;
        end
        if (r_busy && w_out_free) begin
            r_obyte <= w_byte;
            r_oidx  <= r_idx;
            r_olast <= w_last;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx < r_job.nbytes))
        else $error("byte index past encoding length");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_olast) |=> r_ovalid)
        else $error("gap inside an encoding");

    a_cont_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_olast) |-> r_obyte[7])
        else $error("continuation bit missing");

endmodule
`default_nettype wire
